// ----- hdl/slis_pkg.sv -----
// shared types and constants for the sorted list with removal at both ends
package slis_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int VAL_W = 32;
  localparam int CNT_OUT_W = 5;

  typedef enum logic [1:0] {
    ACT_INSERT  = 2'd0,
    ACT_POP_MIN = 2'd1,
    ACT_POP_MAX = 2'd2,
    ACT_NOP     = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RSVD  = 2'd3
  } status_t;

  typedef struct packed {
    logic                    ins;
    logic                    shl;
    logic signed [VAL_W-1:0] value;
  } cell_ctl_t;

endpackage

// ----- hdl/slis_cell.sv -----
// one storage cell of the sorted chain: insert shifts right, pop-min shifts left
module slis_cell
  import slis_pkg::*;
(
  input  logic                    clk,
  input  cell_ctl_t               ctl,
  input  logic                    occ,
  input  logic                    left_ge,
  input  logic signed [VAL_W-1:0] left_data,
  input  logic signed [VAL_W-1:0] right_data,
  output logic                    ge,
  output logic signed [VAL_W-1:0] data
);

  logic signed [VAL_W-1:0] data_r;
  logic signed [VAL_W-1:0] data_nxt;

  assign ge   = occ && (data_r >= ctl.value);
  assign data = data_r;

  always_comb begin
    data_nxt = data_r;
    if (ctl.ins) begin
      if (left_ge) begin
        data_nxt = left_data;
      end else if (!occ || ge) begin
        data_nxt = ctl.value;
      end
    end else if (ctl.shl) begin
      data_nxt = right_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

// ----- hdl/sorted_list_insert_delete_ends_top.sv -----
// top level of the sorted list with insert and removal at both ends
//
// keeps up to CAPACITY signed 32-bit values in ascending order in a row of
// cells. an input item (in_tuser = action, in_tdata = value) inserts a value
// after all smaller ones and before equal ones, removes the smallest, or
// removes the largest, or does nothing. every item gives one result item with status,
// removed value, count and the smallest and largest values kept.
// the chain updates all cells at the edge that accepts the item; the edge
// that moves the pending result on reads the new smallest and largest (a
// count-indexed select over the cells) into the output register once it is
// empty or being read. no new item is accepted while a result is pending.
// in_tready is low while a result is being formed; a finished result waits
// in the output register while the next item is accepted, and when the
// receiver stalls with both full, in_tready stays low until out_tready.
// reset (rst_n low, synchronous) empties the list and drops any result;
// cell contents are not cleared, only the count.
module sorted_list_insert_delete_ends_top
  import slis_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [31:0]   in_tdata,   // value[31:0]
  input  logic [1:0]    in_tuser,   // action[1:0]
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [103:0]  out_tdata,  // removed_value[31:0], count[36:32],
                                    // smallest_value[68:37], largest_value[100:69]
  output logic [2:0]    out_tuser   // status[1:0], removed_valid[2]
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             pend_r;
  status_t          pend_status_r;
  logic             pend_rvalid_r;
  logic signed [VAL_W-1:0] pend_rval_r;

  logic         out_valid_r;
  status_t      out_status_r;
  logic         out_rvalid_r;
  logic signed [VAL_W-1:0] out_rval_r, out_min_r, out_max_r;
  logic [CNT_OUT_W-1:0]    out_cnt_r;

  cell_ctl_t ctl;
  logic signed [VAL_W-1:0] data_w [CAPACITY];
  logic [CAPACITY-1:0]     ge_w;
  logic [CAPACITY-1:0]     occ_w;
  logic [IDX_W-1:0]        last_idx;
  logic signed [VAL_W-1:0] last_val;

  logic    in_fire;
  logic    out_load;
  action_t act;
  logic    is_empty, is_full;
  status_t status_c;
  logic    rvalid_c;
  logic signed [VAL_W-1:0] rval_c;

  assign in_tready = rst_n && !pend_r;
  assign in_fire   = in_tvalid && in_tready;
  assign act       = action_t'(in_tuser);
  assign is_empty  = (count_r == '0);
  assign is_full   = (count_r == CNT_W'(CAPACITY));
  assign out_load  = pend_r && (!out_valid_r || out_tready);

  assign last_idx = IDX_W'(count_r - 1'b1);
  assign last_val = data_w[last_idx];

  always_comb begin
    status_c  = ST_DONE;
    rvalid_c  = 1'b0;
    rval_c    = '0;
    count_nxt = count_r;
    ctl.ins   = 1'b0;
    ctl.shl   = 1'b0;
    ctl.value = $signed(in_tdata);
    if (in_fire) begin
      case (act)
        ACT_INSERT: begin
          if (is_full) begin
            status_c = ST_FULL;
          end else begin
            ctl.ins   = 1'b1;
            count_nxt = count_r + 1'b1;
          end
        end
        ACT_POP_MIN, ACT_POP_MAX: begin
          if (is_empty) begin
            status_c = ST_EMPTY;
          end else begin
            rvalid_c  = 1'b1;
            rval_c    = (act == ACT_POP_MIN) ? data_w[0] : last_val;
            ctl.shl   = (act == ACT_POP_MIN);
            count_nxt = count_r - 1'b1;
          end
        end
        default: begin
          status_c = ST_DONE;
        end
      endcase
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                    l_ge;
    logic signed [VAL_W-1:0] l_data, r_data;
    assign occ_w[i] = (CNT_W'(i) < count_r);
    if (i == 0) begin : g_first
      assign l_ge   = 1'b0;
      assign l_data = '0;
    end else begin : g_mid
      assign l_ge   = ge_w[i-1];
      assign l_data = data_w[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign r_data = data_w[i];
    end else begin : g_inner
      assign r_data = data_w[i+1];
    end
    slis_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .occ        (occ_w[i]),
      .left_ge    (l_ge),
      .left_data  (l_data),
      .right_data (r_data),
      .ge         (ge_w[i]),
      .data       (data_w[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (in_fire) begin
        pend_r <= 1'b1;
      end else if (out_load) begin
        pend_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      pend_status_r <= status_c;
      pend_rvalid_r <= rvalid_c;
      pend_rval_r   <= rval_c;
    end
    if (out_load) begin
      out_status_r <= pend_status_r;
      out_rvalid_r <= pend_rvalid_r;
      out_rval_r   <= pend_rval_r;
      out_cnt_r    <= CNT_OUT_W'(count_r);
      out_min_r    <= is_empty ? '0 : data_w[0];
      out_max_r    <= is_empty ? '0 : last_val;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = {out_rvalid_r, out_status_r};
  assign out_tdata  = {3'b000, out_max_r, out_min_r, out_cnt_r, out_rval_r};

  // checks on the cell chain and the item flow
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("count above capacity");

  a_fire_pend: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> pend_r)
    else $error("accepted item did not start a result");

  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r >= CNT_W'(2)) |-> (data_w[0] <= data_w[1]))
    else $error("first two cells out of order");

  a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && is_empty && (act == ACT_POP_MIN || act == ACT_POP_MAX))
      |=> (count_r == '0))
    else $error("removal on empty list changed count");

endmodule

// ----- tb/sv/tb_sorted_list_insert_delete_ends_top.sv -----
`timescale 1ns / 1ps
// testbench for the sorted list top: directed and random items checked against a list model
module tb_sorted_list_insert_delete_ends_top;
  import slis_pkg::*;

  localparam int CAPACITY    = CAPACITY_DEF;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    status_t            status;
    logic               removed_valid;
    logic signed [31:0] removed_value;
    logic [4:0]         count;
    logic signed [31:0] smallest_value;
    logic signed [31:0] largest_value;
  } list_result_t;

  logic          clk = 1'b0;
  logic          rst_n;
  logic          in_tvalid;
  logic          in_tready;
  logic [31:0]   in_tdata;   // value[31:0]
  logic [1:0]    in_tuser;   // action[1:0]
  logic          out_tvalid;
  logic          out_tready = 1'b0;
  logic [103:0]  out_tdata;  // removed_value[31:0], count[36:32],
                             // smallest_value[68:37], largest_value[100:69]
  logic [2:0]    out_tuser;  // status[1:0], removed_valid[2]

  logic signed [31:0] sorted_store[$];
  list_result_t       pending_results[$];
  int                 errors = 0;
  int                 idle_pct = 0;
  int                 stall_left = 0;
  int                 cycle_count = 0;

  sorted_list_insert_delete_ends_top #(.CAPACITY(CAPACITY)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic list_result_t apply_to_list(action_t act, logic signed [31:0] val);
    list_result_t r;
    int pos;
    r.status        = ST_DONE;
    r.removed_valid = 1'b0;
    r.removed_value = '0;
    pos = 0;
    case (act)
      ACT_INSERT: begin
        if (sorted_store.size() >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          while (pos < sorted_store.size() && sorted_store[pos] < val) pos++;
          sorted_store.insert(pos, val);
        end
      end
      ACT_POP_MIN, ACT_POP_MAX: begin
        if (sorted_store.size() == 0) begin
          r.status = ST_EMPTY;
        end else if (act == ACT_POP_MIN) begin
          r.removed_valid = 1'b1;
          r.removed_value = sorted_store.pop_front();
        end else begin
          r.removed_valid = 1'b1;
          r.removed_value = sorted_store.pop_back();
        end
      end
      default: ;
    endcase
    r.count = 5'(sorted_store.size());
    if (sorted_store.size() == 0) begin
      r.smallest_value = '0;
      r.largest_value  = '0;
    end else begin
      r.smallest_value = sorted_store[0];
      r.largest_value  = sorted_store[sorted_store.size() - 1];
    end
    return r;
  endfunction

  task automatic send_item(action_t act, logic [31:0] val);
    int gap;
    gap = 0;
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) gap = $urandom_range(1, 5);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= val;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(apply_to_list(act, val));
  endtask

  // receiver stalls
  always @(posedge clk) begin
    if (idle_pct == 0) begin
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 99) < idle_pct) begin
      stall_left <= $urandom_range(0, 4);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s: expected %0h, actual %0h", name, exp_val, act_val);
      errors++;
    end
  endtask

  always @(posedge clk) begin : result_check
    list_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("result item with no expected result waiting");
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        check_field("status", 32'(exp_r.status), 32'(out_tuser[1:0]));
        check_field("removed_valid", 32'(exp_r.removed_valid), 32'(out_tuser[2]));
        check_field("removed_value", exp_r.removed_value, out_tdata[31:0]);
        check_field("count", 32'(exp_r.count), 32'(out_tdata[36:32]));
        check_field("smallest_value", exp_r.smallest_value, out_tdata[68:37]);
        check_field("largest_value", exp_r.largest_value, out_tdata[100:69]);
      end
    end
  end

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000 + $urandom_range(0, 3);
      1:       return 32'h7fff_ffff - $urandom_range(0, 3);
      2, 3, 4: return $urandom_range(0, 7) - 4;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_empty_removals();
    send_item(ACT_POP_MIN, 32'hffff_ffff);
    send_item(ACT_POP_MAX, 32'h0000_0000);
    send_item(ACT_NOP, 32'h1234_5678);
  endtask

  task automatic test_extreme_values();
    send_item(ACT_INSERT, 32'h8000_0000);
    send_item(ACT_INSERT, 32'h7fff_ffff);
    send_item(ACT_INSERT, 32'h0000_0000);
    send_item(ACT_INSERT, 32'hffff_ffff);
    send_item(ACT_INSERT, 32'h0000_0000);
    send_item(ACT_POP_MIN, 32'h5555_5555);
    send_item(ACT_POP_MAX, 32'haaaa_aaaa);
  endtask

  task automatic test_fill_to_capacity();
    int k;
    k = 0;
    while (sorted_store.size() < CAPACITY) begin
      send_item(ACT_INSERT, k * 7 - 40);
      k++;
    end
    send_item(ACT_INSERT, 32'h0000_0001);
    send_item(ACT_NOP, 32'hdead_beef);
  endtask

  task automatic test_random_mix(int n_items, bit with_idling);
    int ins_pct;
    int r;
    action_t act;
    for (int i = 0; i < n_items; i++) begin
      if (i % 50 == 0) begin
        ins_pct = $urandom_range(15, 85);
        if (with_idling) begin
          case ($urandom_range(0, 3))
            0:       idle_pct = 0;
            1:       idle_pct = 10;
            2:       idle_pct = 30;
            default: idle_pct = 60;
          endcase
        end
      end
      r = $urandom_range(0, 99);
      if (r < 3) act = ACT_NOP;
      else if (r < 3 + ins_pct) act = ACT_INSERT;
      else if (r[0]) act = ACT_POP_MIN;
      else act = ACT_POP_MAX;
      send_item(act, (act == ACT_INSERT) ? pick_value() : $urandom);
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    idle_pct = 30;
    test_empty_removals();
    test_extreme_values();
    test_fill_to_capacity();
    test_random_mix(700, 1'b1);
    idle_pct = 0;
    test_random_mix(150, 1'b0);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
